FILE: src/oldest_active_stamp_tracker_core_defines.svh
// assertion macros for the oldest active stamp tracker
`ifndef OLDEST_ACTIVE_STAMP_TRACKER_CORE_DEFINES_SVH
`define OLDEST_ACTIVE_STAMP_TRACKER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define OAST_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define OAST_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define OAST_ASSERT(label, prop, msg)
`define OAST_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: src/oast_pkg.sv
// shared constants and types for the oldest active stamp tracker
package oast_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int STAMP_W = 32;
    localparam int ENTRY_W = 5;

    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef struct packed {
        logic               shift_in;
        logic               shift_out;
        logic [STAMP_W-1:0] stamp;
    } t_cell_ctrl;

endpackage

FILE: src/oldest_active_stamp_tracker_core.sv
// top level of the oldest active stamp tracker
// One item is taken per clock; busy is never raised. An item accepted on start is
// registered, compared against every entry in parallel and applied to the sorted store
// while its result is registered. o_done is then high for one cycle. The receiver cannot
// stall, so the result must be taken in that cycle.
// Inserts into a full store are dropped with status full; removes of an absent stamp
// change nothing and report not found. Entry count shows the full count of stored entries.
`include "oldest_active_stamp_tracker_core_defines.svh"

module oldest_active_stamp_tracker_core
    import oast_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_action,
    input  logic [STAMP_W-1:0] i_stamp,
    output logic               o_done,
    output logic [STAMP_W-1:0] o_oldest,
    output logic               o_any_present,
    output logic [ENTRY_W-1:0] o_entry_count,
    output logic [1:0]         o_status
);

    logic               r_in_valid;
    logic               r_action;
    logic [STAMP_W-1:0] r_stamp;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_out_valid;
    logic [STAMP_W-1:0] r_oldest;
    logic               r_any;
    logic [ENTRY_W-1:0] r_entry_count;
    t_status            r_status;
    t_status            n_status;

    logic [STAMP_W-1:0] entry [DEPTH];
    logic [DEPTH-1:0]   lt;
    logic [DEPTH-1:0]   eq;
    logic               full;
    logic               found;
    logic               is_insert;
    logic               is_remove;
    t_cell_ctrl         ctrl;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= i_action;
        r_stamp  <= i_stamp;
    end

    assign full      = (r_count == CNT_W'(DEPTH));
    assign found     = |eq;
    assign is_insert = r_in_valid && (t_action'(r_action) == ACT_INSERT);
    assign is_remove = r_in_valid && (t_action'(r_action) == ACT_REMOVE);

    assign ctrl.shift_in  = is_insert && !full;
    assign ctrl.shift_out = is_remove && found;
    assign ctrl.stamp     = r_stamp;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        oast_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (ctrl),
            .i_in_use     (CNT_W'(g) < r_count),
            .i_take_stamp ((g == 0) ? 1'b1 : lt[(g == 0) ? 0 : g - 1]),
            .i_lower      ((g == 0) ? r_stamp : entry[(g == 0) ? 0 : g - 1]),
            .i_upper      ((g == DEPTH - 1) ? entry[g] : entry[(g == DEPTH - 1) ? g : g + 1]),
            .o_entry      (entry[g]),
            .o_lt         (lt[g]),
            .o_eq         (eq[g])
        );
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_DONE;
        if (is_insert) begin
            if (full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else if (is_remove) begin
            if (found) begin
                n_count = r_count - CNT_W'(1);
            end else begin
                n_status = ST_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= r_in_valid;
        end
    end

    // store head after the shift, taken from the cells' next-value sources
    logic [STAMP_W-1:0] n_head;
    always_comb begin
        n_head = entry[0];
        if (ctrl.shift_in && !lt[0]) begin
            n_head = r_stamp;
        end else if (ctrl.shift_out && !lt[0]) begin
            n_head = entry[(DEPTH > 1) ? 1 : 0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_oldest      <= (n_count != '0) ? n_head : '0;
        r_any         <= (n_count != '0);
        r_entry_count <= ENTRY_W'(n_count);
        r_status      <= n_status;
    end

    assign o_done        = r_out_valid;
    assign o_oldest      = r_oldest;
    assign o_any_present = r_any;
    assign o_entry_count = r_entry_count;
    assign o_status      = r_status;

    `OAST_ASSERT(a_result_follows, r_in_valid |=> o_done, "result strobe missing after transfer")
    `OAST_ASSERT(a_full_status, (o_done && o_status == ST_FULL) |-> (r_count == CNT_W'(DEPTH)), "full status with room left")
    `OAST_ASSERT(a_keep_on_error, (o_done && o_status != ST_DONE) |-> (r_count == $past(r_count)), "count changed on dropped item")
    `OAST_ASSERT(a_present_flag, o_done |-> (o_any_present == (r_count != '0)), "present flag disagrees with count")
    `OAST_ASSERT(a_count_range, r_count <= CNT_W'(DEPTH), "count beyond store depth")

endmodule

FILE: src/oast_cell.sv
// one entry of the sorted store with its compare and shift logic
module oast_cell
    import oast_pkg::*;
(
    input  logic               i_clk,
    input  t_cell_ctrl         i_ctrl,
    input  logic               i_in_use,
    input  logic               i_take_stamp,
    input  logic [STAMP_W-1:0] i_lower,
    input  logic [STAMP_W-1:0] i_upper,
    output logic [STAMP_W-1:0] o_entry,
    output logic               o_lt,
    output logic               o_eq
);

    logic [STAMP_W-1:0] r_entry;
    logic [STAMP_W-1:0] n_entry;

    assign o_lt    = i_in_use && (r_entry < i_ctrl.stamp);
    assign o_eq    = i_in_use && (r_entry == i_ctrl.stamp);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.shift_in && !o_lt) begin
            n_entry = i_take_stamp ? i_ctrl.stamp : i_lower;
        end else if (i_ctrl.shift_out && !o_lt) begin
            n_entry = i_upper;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule
